FILE: rtl/psq_pkg.sv
// Shared definitions for the positional sequence store.
// Holds sizes, operation and status codes and the cell control type;
// depends on nothing.
package psq_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int OP_W    = 3;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int FPOS_W  = 4;
	localparam int CNT_OUT_W = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_RM_AT  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
	localparam logic [OP_W-1:0] OP_RM_VAL = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	// Cell commands
	localparam logic [1:0] CMD_HOLD  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_LEFT  = 2'd2;
	localparam logic [1:0] CMD_RIGHT = 2'd3;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [1:0] cmd;
		word_t      key;
	} cell_ctl_t;

endpackage

FILE: rtl/psq_cell.sv
// One storage cell of the sequence chain: a word register plus a match compare.
// Depends on psq_pkg.
module psq_cell (
	input  logic              clk,
	input  psq_pkg::cell_ctl_t ctl,
	input  psq_pkg::word_t    left,
	input  psq_pkg::word_t    right,
	output psq_pkg::word_t    data,
	output logic              match
);

	psq_pkg::word_t data_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			psq_pkg::CMD_LOAD:  data_q <= ctl.key;
			psq_pkg::CMD_LEFT:  data_q <= left;
			psq_pkg::CMD_RIGHT: data_q <= right;
			default:            data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == ctl.key);

endmodule

FILE: rtl/positional_sequence_store.sv
// Top level of the positional sequence store: input stage, control, chain of cells
// and output register. Depends on psq_pkg and psq_cell.
//
//   channel | signals                       | direction | word
//   --------+-------------------------------+-----------+------------------------------
//   request | s_tvalid s_tready s_tdata s_tuser | in    | op, pos, value
//   result  | m_tvalid m_tready m_tdata m_tuser | out   | status, read_value, found_pos,
//           |                               |           | count
//
// A request is registered in the input stage; when it executes, all cells are compared,
// the chain shifts and the result loads the output register. The input stage frees in
// the cycle it executes, so one request per cycle is sustained while the result side
// keeps up; the single output register sets that limit. A stalled result holds the input
// stage, and the input stage then holds s_tready low. Reset clears the entry count and
// valid flags; cell contents stay undefined until written and are never read before.
module positional_sequence_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [4:0] pos, [36:5] value, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] read_value, [35:32] found_pos, [40:36] count
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CAP = psq_pkg::CAPACITY;

	// Input stage
	logic                           valid_s1;
	logic [psq_pkg::OP_W-1:0]       op_s1;
	logic [psq_pkg::POS_W-1:0]      pos_s1;
	psq_pkg::word_t                 value_s1;

	logic [psq_pkg::COUNT_W-1:0]    count_q;
	logic                           m_tvalid_q;
	logic [47:0]                    m_tdata_q;
	logic [1:0]                     m_tuser_q;

	logic                           exec;
	logic                           s_fire;

	psq_pkg::cell_ctl_t             ctl   [CAP];
	psq_pkg::word_t                 cdata [CAP];
	logic [CAP-1:0]                 cmatch;
	logic [CAP-1:0]                 live;
	logic [CAP-1:0]                 hit;
	logic                           hit_any;
	logic [psq_pkg::IDX_W-1:0]      where;
	logic                           ins_ok;
	logic                           rm_ok;
	logic [psq_pkg::IDX_W-1:0]      rm_pos;
	logic [psq_pkg::STAT_W-1:0]     status;
	psq_pkg::word_t                 rd_value;
	logic [psq_pkg::FPOS_W-1:0]     found_pos;
	logic [psq_pkg::COUNT_W-1:0]    count_next;

	// Execute when the output register is free or being drained
	assign exec     = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || exec;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1    <= s_tuser;
			pos_s1   <= s_tdata[4:0];
			value_s1 <= s_tdata[psq_pkg::VALUE_WIDTH+4:5];
		end
	end

	// Live mask and first-match search over occupied cells
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			live[i] = (psq_pkg::COUNT_W'(i) < count_q);
		end
		hit     = cmatch & live;
		hit_any = |hit;
		where   = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit[i]) begin
				where = psq_pkg::IDX_W'(i);
			end
		end
	end

	// Decide the operation outcome
	always_comb begin
		ins_ok    = 1'b0;
		rm_ok     = 1'b0;
		rm_pos    = pos_s1[psq_pkg::IDX_W-1:0];
		status    = psq_pkg::ST_OK;
		rd_value  = '0;
		found_pos = '0;
		case (op_s1)
			psq_pkg::OP_INSERT: begin
				if (pos_s1 > psq_pkg::POS_W'(count_q)) begin
					status = psq_pkg::ST_BADPOS;
				end else if (count_q >= psq_pkg::COUNT_W'(CAP)) begin
					status = psq_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			psq_pkg::OP_RM_AT: begin
				if (pos_s1 >= psq_pkg::POS_W'(count_q)) begin
					status = psq_pkg::ST_BADPOS;
				end else begin
					rm_ok = 1'b1;
				end
			end
			psq_pkg::OP_READ: begin
				if (pos_s1 >= psq_pkg::POS_W'(count_q)) begin
					status = psq_pkg::ST_BADPOS;
				end else begin
					rd_value = cdata[pos_s1[psq_pkg::IDX_W-1:0]];
				end
			end
			psq_pkg::OP_FIND, psq_pkg::OP_RM_VAL: begin
				if (!hit_any) begin
					status = psq_pkg::ST_NOTFOUND;
				end else begin
					found_pos = psq_pkg::FPOS_W'(where);
					rm_ok     = (op_s1 == psq_pkg::OP_RM_VAL);
					rm_pos    = where;
				end
			end
			default: begin
				status = psq_pkg::ST_OK;
			end
		endcase
	end

	// Per-cell commands: open a gap for insert, close it for remove
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			ctl[i].key = value_s1;
			ctl[i].cmd = psq_pkg::CMD_HOLD;
			if (exec && ins_ok) begin
				if (psq_pkg::POS_W'(i) == pos_s1) begin
					ctl[i].cmd = psq_pkg::CMD_LOAD;
				end else if (psq_pkg::POS_W'(i) > pos_s1 &&
						psq_pkg::COUNT_W'(i) <= count_q) begin
					ctl[i].cmd = psq_pkg::CMD_LEFT;
				end
			end else if (exec && rm_ok) begin
				if (psq_pkg::IDX_W'(i) >= rm_pos &&
						psq_pkg::COUNT_W'(i + 1) < count_q) begin
					ctl[i].cmd = psq_pkg::CMD_RIGHT;
				end
			end
		end
	end

	// Chain of cells; the ends feed back their own word
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		psq_cell u_cell (
			.clk   (clk),
			.ctl   (ctl[g]),
			.left  ((g == 0) ? cdata[g] : cdata[(g == 0) ? 0 : g - 1]),
			.right ((g == CAP - 1) ? cdata[g] : cdata[(g == CAP - 1) ? g : g + 1]),
			.data  (cdata[g]),
			.match (cmatch[g])
		);
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + 1'b1;
		end else if (rm_ok) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result word: hold until taken
	always_ff @(posedge clk) begin
		if (exec) begin
			m_tuser_q <= status;
			m_tdata_q <= {7'd0, psq_pkg::CNT_OUT_W'(count_next), found_pos, rd_value};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= psq_pkg::COUNT_W'(CAP))
		else $error("entry count above capacity");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !exec |=> valid_s1)
		else $error("input stage dropped a stalled request");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		exec && ins_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		exec && rm_ok |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shrink the count");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins_ok && rm_ok))
		else $error("insert and remove decided together");
`endif

endmodule
